// File: design/brxre_pkg.sv
package brxre_pkg;

    // Longest run that one header byte can carry
    localparam logic [6:0] RUN_MAX     = 7'd127;
    // A lone byte below this value goes out as a literal
    localparam logic [7:0] LIT_LIMIT   = 8'd129;
    // Number of closed runs held between front and back
    localparam int         QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] value;
        logic [6:0] length;
        logic       last;
    } t_run;

endpackage

// File: design/bitmap_row_xor_rle_encoder.sv
// Row-delta XOR run-length encoder for packed 1-bit glyph bitmaps.
// Input channel (i_in_valid/o_in_ready): one bitmap byte per transfer,
// rows in order, i_last_byte on the final byte of the bitmap.
// Output channel (o_out_valid/i_out_ready): encoded bytes, literals or
// header/value pairs, o_last_out on the final byte of the bitmap.
// Config channel (i_cfg_valid/o_cfg_ready): glyph width in pixels, always
// ready; write it only while no bitmap is in flight.
// The first byte of a closed run passes from the front run stage through
// the queue and the current-run register of the back end to its output
// register. Throughput: one input per cycle while runs extend; an input
// that closes a run yields a literal or a header/value pair, which leaves
// through the single output register of the back end. A last byte that
// closes a run and opens its own pushes twice from the front run stage.
// A queue of four closed runs separates the front from the back; when the
// receiver stalls the output holds, the queue fills, then o_in_ready drops once a run must be pushed.
// Reset clears all control state and sets the width to 8 pixels; the line
// store is not cleared and its contents are only used for rows after row 0.
module bitmap_row_xor_rle_encoder import brxre_pkg::*; #(
    parameter int MAX_ROW_BYTES = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [8:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_out
);

    logic [8:0] r_row_width_pixels;
    logic       w_push;
    t_run       w_push_run;
    logic       w_push_ready;
    logic       w_pop_valid;
    t_run       w_pop_run;
    logic       w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width_pixels <= 9'd8;
        end else if (i_cfg_valid) begin
            r_row_width_pixels <= i_cfg_data;
        end
    end

    brxre_front #(
        .MAX_ROW_BYTES(MAX_ROW_BYTES)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_row_width_pixels(r_row_width_pixels),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_data_byte       (i_data_byte),
        .i_last_byte       (i_last_byte),
        .o_push            (w_push),
        .o_push_run        (w_push_run),
        .i_push_ready      (w_push_ready)
    );

    brxre_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_run  (w_push_run),
        .o_push_ready(w_push_ready),
        .o_pop_valid (w_pop_valid),
        .o_pop_run   (w_pop_run),
        .i_pop       (w_pop)
    );

    brxre_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pop_valid(w_pop_valid),
        .i_pop_run  (w_pop_run),
        .o_pop      (w_pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_byte (o_out_byte),
        .o_last_out (o_last_out)
    );

endmodule

// File: design/brxre_front.sv
module brxre_front import brxre_pkg::*; #(
    parameter int MAX_ROW_BYTES = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [8:0] i_row_width_pixels,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_push,
    output t_run       o_push_run,
    input  logic       i_push_ready
);

    localparam int ColW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

    logic [7:0]      r_line [MAX_ROW_BYTES];
    logic [7:0]      r_rd;
    logic [ColW-1:0] r_col;
    logic            r_first;

    logic            r_b_valid;
    logic [7:0]      r_b_byte;
    logic            r_b_last;
    logic            r_b_first;
    logic            r_b_phase;
    logic [7:0]      r_run_value;
    logic [6:0]      r_run_len;

    logic [9:0]      w_sum;
    logic [6:0]      w_raw;
    logic [8:0]      w_row_bytes;
    logic [8:0]      w_col_inc;
    logic            w_in_acc;
    logic [7:0]      w_delta;
    logic            w_close;
    logic [6:0]      w_ext_len;
    logic            w_push_req;
    logic            w_push_ok;
    logic            w_b_done;
    logic            w_run_step;

    // Row byte count: width rounded up over eight, at least one, clamped to the line store
    assign w_sum = {1'b0, i_row_width_pixels} + 10'd7;
    assign w_raw = w_sum[9:3];

    always_comb begin
        if (w_raw == 7'd0) begin
            w_row_bytes = 9'd1;
        end else if ({2'b00, w_raw} > 9'(MAX_ROW_BYTES)) begin
            w_row_bytes = 9'(MAX_ROW_BYTES);
        end else begin
            w_row_bytes = {2'b00, w_raw};
        end
    end

    assign w_col_inc = 9'(r_col) + 9'd1;
    assign w_in_acc  = i_in_valid && o_in_ready;

    // Read of the row above and write of the raw byte share the accept edge
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_rd          <= r_line[r_col];
            r_line[r_col] <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_first <= 1'b1;
        end else if (w_in_acc) begin
            if (i_last_byte) begin
                r_col   <= '0;
                r_first <= 1'b1;
            end else if (w_col_inc >= w_row_bytes) begin
                r_col   <= '0;
                r_first <= 1'b0;
            end else begin
                r_col   <= ColW'(w_col_inc);
            end
        end
    end

    // Run stage
    assign w_delta   = r_b_first ? r_b_byte : (r_b_byte ^ r_rd);
    assign w_close   = (r_run_len != 7'd0) &&
                       !((w_delta == r_run_value) && (r_run_len < RUN_MAX));
    assign w_ext_len = (w_close || (r_run_len == 7'd0)) ? 7'd1 : (r_run_len + 7'd1);

    // A last byte that closes a run pushes twice: old run, then its own
    assign w_push_req = r_b_valid && (r_b_phase || w_close || r_b_last);
    assign w_push_ok  = w_push_req && i_push_ready;
    assign w_b_done   = r_b_valid &&
                        (w_push_req ? (w_push_ok && (r_b_phase || !(w_close && r_b_last)))
                                    : 1'b1);
    assign w_run_step = (r_b_valid && !w_push_req) || w_push_ok;

    assign o_in_ready = !r_b_valid || w_b_done;
    assign o_push     = w_push_req;

    always_comb begin
        if (r_b_phase) begin
            o_push_run = '{value: r_run_value, length: r_run_len, last: 1'b1};
        end else if (w_close) begin
            o_push_run = '{value: r_run_value, length: r_run_len, last: 1'b0};
        end else begin
            o_push_run = '{value: w_delta, length: w_ext_len, last: 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_b_byte  <= i_data_byte;
            r_b_last  <= i_last_byte;
            r_b_first <= r_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_b_phase   <= 1'b0;
            r_run_value <= 8'd0;
            r_run_len   <= 7'd0;
        end else begin
            if (w_in_acc) begin
                r_b_valid <= 1'b1;
            end else if (w_b_done) begin
                r_b_valid <= 1'b0;
            end
            if (w_run_step) begin
                if (r_b_phase) begin
                    r_run_value <= 8'd0;
                    r_run_len   <= 7'd0;
                    r_b_phase   <= 1'b0;
                end else if (w_close && r_b_last) begin
                    r_run_value <= w_delta;
                    r_run_len   <= 7'd1;
                    r_b_phase   <= 1'b1;
                end else if (r_b_last) begin
                    r_run_value <= 8'd0;
                    r_run_len   <= 7'd0;
                end else begin
                    r_run_value <= w_delta;
                    r_run_len   <= w_ext_len;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_phase_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_phase |-> (r_b_valid && r_b_last))
        else $error("second push phase without a held last byte");

    a_run_cleared_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_ok && o_push_run.last) |=> (r_run_len == 7'd0))
        else $error("run still open after final push");
`endif

endmodule

// File: design/brxre_queue.sv
module brxre_queue import brxre_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_run i_push_run,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_run o_pop_run,
    input  logic i_pop
);

    localparam int PtrW = $clog2(QUEUE_DEPTH);

    t_run          r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [PtrW:0]   r_count;
    logic            w_push;
    logic            w_pop;

    assign o_push_ready = (r_count != (PtrW+1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_run    = r_mem[r_rd];
    assign w_push       = i_push && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= PtrW'(r_wr + 1'b1);
            end
            if (w_pop) begin
                r_rd <= PtrW'(r_rd + 1'b1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PtrW+1)'(QUEUE_DEPTH))
        else $error("queue count past depth");

    a_pointer_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != (PtrW+1)'(QUEUE_DEPTH) && r_count != '0) |-> (r_wr != r_rd))
        else $error("queue pointers disagree with count");
`endif

endmodule

// File: design/brxre_back.sv
module brxre_back import brxre_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_pop_valid,
    input  t_run       i_pop_run,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_out
);

    t_run       r_cur;
    logic       r_cur_valid;
    logic       r_step;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic       w_lit;
    logic       w_out_free;
    logic       w_emit;
    logic       w_cur_done;

    assign w_lit      = (r_cur.length == 7'd1) && (r_cur.value < LIT_LIMIT);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_emit     = r_cur_valid && w_out_free;
    assign w_cur_done = w_emit && (r_step || w_lit);
    assign o_pop      = i_pop_valid && (!r_cur_valid || w_cur_done);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_pop_run;
        end
        if (w_emit) begin
            // header carries the length with the top bit set
            r_out_byte <= (r_step || w_lit) ? r_cur.value : {1'b1, r_cur.length};
            r_out_last <= (r_step || w_lit) ? r_cur.last : 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_step      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cur_valid <= 1'b1;
            end else if (w_cur_done) begin
                r_cur_valid <= 1'b0;
            end
            if (w_emit) begin
                r_step <= !w_cur_done;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_out  = r_out_last;

`ifndef SYNTHESIS
    a_step_on_header_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step |-> (r_cur_valid && !w_lit))
        else $error("value step on a literal or empty slot");
`endif

endmodule

// File: verif/tb_bitmap_row_xor_rle_encoder.sv
module tb_bitmap_row_xor_rle_encoder;

    localparam int          MAX_ROW       = 32;
    localparam int unsigned RUN_CAP       = 127;
    localparam logic [7:0]  LITERAL_BELOW = 8'd129;
    localparam logic [7:0]  HDR_FLAG      = 8'h80;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          TAIL_CYCLES   = 16;
    localparam int          HOLD_CYCLES   = 100;
    localparam int          STUCK_LIMIT   = 3000;
    localparam int          ITEM_GOAL     = 360;
    localparam int          QUIET_AFTER   = 300;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_code;

    typedef enum logic {ROW_BYTE, ROW_WIDTH} t_row_kind;

    typedef enum int {DELTA_MIXED, DELTA_RUNS, DELTA_NOISE} t_delta_mode;

    // n_typed > 0: the coded bytes are written here, last flag on the final one
    typedef struct packed {
        t_row_kind  kind;
        logic [8:0] val;
        logic       last;
        logic [1:0] n_typed;
        logic [7:0] t0;
        logic [7:0] t1;
    } t_row;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [8:0] i_cfg_data  = '0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_data_byte = '0;
    logic       i_last_byte = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b1;
    logic [7:0] o_out_byte;
    logic       o_last_out;

    bitmap_row_xor_rle_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_last_out  (o_last_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // encoder shadow state
    logic [7:0]  line_store [MAX_ROW];
    int unsigned column    = 0;
    bit          first_row = 1'b1;
    logic [7:0]  run_val   = 8'd0;
    int unsigned run_len   = 0;
    logic [8:0]  width_px  = 9'd8;

    t_code step_codes[$];
    t_code code_due_q[$];

    int  mismatches  = 0;
    int  codes_seen  = 0;
    int  items_fed   = 0;
    int  stuck_cycles = 0;
    bit  quiet    = 1'b0;
    bit  tx_calm  = 1'b0;
    bit  rx_calm  = 1'b0;
    bit  hold_req = 1'b0;

    t_row plan [23] = '{
        '{ROW_BYTE,  9'h000, 1'b1, 2'd1, 8'h00, 8'h00},
        '{ROW_BYTE,  9'h0FF, 1'b1, 2'd2, 8'h81, 8'hFF},
        '{ROW_BYTE,  9'h080, 1'b1, 2'd1, 8'h80, 8'h00},
        '{ROW_BYTE,  9'h081, 1'b1, 2'd2, 8'h81, 8'h81},
        '{ROW_WIDTH, 9'd0,   1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_BYTE,  9'h012, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_BYTE,  9'h012, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_BYTE,  9'h012, 1'b0, 2'd0, 8'h00, 8'h00},
        // closes a zero run and opens a run of its own above the literal range
        '{ROW_BYTE,  9'h0D1, 1'b1, 2'd0, 8'h00, 8'h00},
        '{ROW_WIDTH, 9'd511, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_BYTE,  9'h0A5, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_BYTE,  9'h05A, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_BYTE,  9'h07F, 1'b0, 2'd0, 8'h00, 8'h00},
        // narrowed mid-bitmap: column already past the new row end
        '{ROW_WIDTH, 9'd9,   1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_BYTE,  9'h001, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_BYTE,  9'h0A5, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_BYTE,  9'h05A, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_BYTE,  9'h000, 1'b1, 2'd0, 8'h00, 8'h00},
        '{ROW_WIDTH, 9'd256, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_BYTE,  9'h000, 1'b1, 2'd0, 8'h00, 8'h00},
        '{ROW_WIDTH, 9'd1,   1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_BYTE,  9'h0FE, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_BYTE,  9'h0FE, 1'b1, 2'd0, 8'h00, 8'h00}
    };

    function automatic int unsigned bytes_per_row();
        int unsigned n;
        n = (32'(width_px) + 7) / 8;
        if (n < 1) n = 1;
        if (n > MAX_ROW) n = MAX_ROW;
        return n;
    endfunction

    function automatic void close_run();
        if (run_len == 1 && run_val < LITERAL_BELOW) begin
            step_codes.push_back('{run_val, 1'b0});
        end else begin
            step_codes.push_back('{HDR_FLAG | 8'(run_len), 1'b0});
            step_codes.push_back('{run_val, 1'b0});
        end
    endfunction

    // one byte through the row delta and the run coder; codes land in step_codes
    function automatic void xor_rle_step(input logic [7:0] b, input logic fin);
        int unsigned n;
        int unsigned col;
        logic [7:0]  d;
        step_codes.delete();
        n   = bytes_per_row();
        col = (column >= MAX_ROW) ? 0 : column;
        d   = first_row ? b : (b ^ line_store[col]);
        line_store[col] = b;
        if (col + 1 >= n) begin
            column    = 0;
            first_row = 1'b0;
        end else begin
            column = col + 1;
        end
        if (run_len != 0 && d == run_val && run_len < RUN_CAP) begin
            run_len++;
        end else begin
            if (run_len != 0) close_run();
            run_val = d;
            run_len = 1;
        end
        if (fin) begin
            close_run();
            step_codes[step_codes.size() - 1].last = 1'b1;
            column    = 0;
            first_row = 1'b1;
            run_val   = 8'd0;
            run_len   = 0;
        end
    endfunction

    task automatic note_mismatch(input string msg);
        $display("MISMATCH at code %0d: %s", codes_seen, msg);
        mismatches++;
    endtask

    task automatic feed_byte(input logic [7:0] b, input logic fin, input bit by_model);
        if (!tx_calm && !quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= fin;
        do @(posedge i_clk); while (!o_in_ready);
        xor_rle_step(b, fin);
        items_fed++;
        if (by_model) begin
            foreach (step_codes[k]) code_due_q.push_back(step_codes[k]);
        end
    endtask

    // drain, give the front end time to settle, then write the width
    task automatic write_width(input logic [8:0] px);
        i_in_valid <= 1'b0;
        while (code_due_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= px;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        width_px = px;
    endtask

    // output side: checks each transfer and drives ready
    int hold_left  = 0;
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_code want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (code_due_q.size() == 0) begin
                note_mismatch($sformatf("unexpected byte %02h last %0b",
                                        o_out_byte, o_last_out));
            end else begin
                want = code_due_q.pop_front();
                if (o_out_byte !== want.code)
                    note_mismatch($sformatf("out_byte %02h, want %02h",
                                            o_out_byte, want.code));
                if (o_last_out !== want.last)
                    note_mismatch($sformatf("last_out %0b, want %0b",
                                            o_last_out, want.last));
            end
            codes_seen++;
        end
        if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (!quiet && !rx_calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 12);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("bitmap_row_xor_rle_encoder verification failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        int          bmp;
        int          len;
        int          r;
        t_delta_mode mode;
        logic [7:0]  d;
        logic [7:0]  b;
        int unsigned col;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WIDTH) begin
                write_width(plan[i].val);
            end else if (plan[i].n_typed == 0) begin
                feed_byte(plan[i].val[7:0], plan[i].last, 1'b1);
            end else begin
                feed_byte(plan[i].val[7:0], plan[i].last, 1'b0);
                code_due_q.push_back('{plan[i].t0, plan[i].n_typed == 2'd1});
                if (plan[i].n_typed == 2'd2) code_due_q.push_back('{plan[i].t1, 1'b1});
            end
        end

        bmp = 0;
        while (items_fed < ITEM_GOAL) begin
            if (bmp > 1 && $urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 10))
                    0:       write_width(9'd0);
                    1:       write_width(9'd1);
                    2:       write_width(9'd7);
                    3:       write_width(9'd8);
                    4:       write_width(9'd9);
                    5:       write_width(9'd255);
                    6:       write_width(9'd256);
                    7:       write_width(9'd257);
                    8:       write_width(9'd511);
                    default: write_width(9'($urandom_range(0, 64)));
                endcase
            end
            if (bmp == 0) begin
                // long repeated-delta stretch to hit the run length cap
                mode    = DELTA_RUNS;
                len     = $urandom_range(130, 200);
                tx_calm = 1'b0;
            end else if (bmp == 1) begin
                // receiver holds off while the sender keeps offering
                mode     = DELTA_NOISE;
                len      = 40;
                tx_calm  = 1'b1;
                hold_req = 1'b1;
            end else begin
                r       = $urandom_range(0, 9);
                mode    = (r < 7) ? DELTA_MIXED : (r < 8) ? DELTA_RUNS : DELTA_NOISE;
                len     = (mode == DELTA_RUNS) ? $urandom_range(1, 40) : $urandom_range(1, 24);
                tx_calm = ($urandom_range(0, 3) == 0);
            end
            for (int i = 0; i < len; i++) begin
                r = $urandom_range(0, 99);
                if (run_len != 0 && ((mode == DELTA_RUNS && r < 97)
                                     || (mode == DELTA_MIXED && r < 40))) begin
                    d = run_val;
                end else if (mode == DELTA_MIXED && r < 55) begin
                    d = 8'd0;
                end else if (mode == DELTA_MIXED && r < 70) begin
                    case ($urandom_range(0, 3))
                        0:       d = 8'd127;
                        1:       d = 8'd128;
                        2:       d = 8'd129;
                        default: d = 8'd255;
                    endcase
                end else begin
                    d = 8'($urandom_range(0, 255));
                end
                col = (column >= MAX_ROW) ? 0 : column;
                b   = first_row ? d : (d ^ line_store[col]);
                feed_byte(b, i == len - 1, 1'b1);
                if (items_fed >= QUIET_AFTER) quiet = 1'b1;
            end
            bmp++;
        end

        i_in_valid <= 1'b0;
        while (code_due_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("bitmap_row_xor_rle_encoder verification clean");
        end else begin
            $display("bitmap_row_xor_rle_encoder verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
design/brxre_pkg.sv
design/brxre_front.sv
design/brxre_queue.sv
design/brxre_back.sv
design/bitmap_row_xor_rle_encoder.sv
verif/tb_bitmap_row_xor_rle_encoder.sv
